FILE: sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ptt_pkg.sv
// shared types, constants and the tanh knot table of the perceptron trainer
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

  localparam int W_W       = 24;           // weight width, signed q7.16
  localparam int S_W       = 16;           // sample width, signed q1.14
  localparam int LR_W      = 16;           // learning rate width, unsigned q0.16
  localparam int NUM_W     = 3;            // x, y, bias
  localparam int MUL_A_W   = 34;           // shared multiplier operand a
  localparam int MUL_B_W   = 17;           // shared multiplier operand b
  localparam int ACC_W     = 42;           // dot product accumulator
  localparam int SUM_SHIFT = 14;           // accumulator to q.16
  localparam int UPD_SHIFT = 28;           // update product to q7.16
  localparam int ERR_W     = 17;

  localparam logic [LR_W-1:0]         LR_RESET  = 16'd655;
  localparam logic signed [S_W-1:0]   ONE_Q14   = 16'sd16384;
  localparam logic [1:0]              LAST_LANE = 2'(NUM_W - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL0  = 12'b000000000010,
    S_MUL1  = 12'b000000000100,
    S_MUL2  = 12'b000000001000,
    S_SUM   = 12'b000000010000,
    S_ABS   = 12'b000000100000,
    S_TMUL  = 12'b000001000000,
    S_PRED  = 12'b000010000000,
    S_LRERR = 12'b000100000000,
    S_LRCAP = 12'b001000000000,
    S_UMUL  = 12'b010000000000,
    S_UADD  = 12'b100000000000
  } state_t;

  typedef struct packed {
    state_t     state;
    logic [1:0] idx;
  } ctrl_t;

  typedef struct packed {
    logic train;
    logic out_free;
  } stat_t;

  // tanh at steps of 0.5, q1.14
  function automatic logic [14:0] tanh_knot(input logic [3:0] seg);
    logic [14:0] k;
    case (seg)
      4'd0:    k = 15'd0;
      4'd1:    k = 15'd7571;
      4'd2:    k = 15'd12478;
      4'd3:    k = 15'd14830;
      4'd4:    k = 15'd15795;
      4'd5:    k = 15'd16165;
      4'd6:    k = 15'd16303;
      4'd7:    k = 15'd16354;
      default: k = 15'd16384;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ptt_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module ptt_mul #(
  parameter int A_W = ptt_pkg::MUL_A_W,
  parameter int B_W = ptt_pkg::MUL_B_W
) (
  input  wire logic                     clk,
  input  wire logic signed [A_W-1:0]    a,
  input  wire logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0]     p
);

  always_ff @(posedge clk) begin
    p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule
`default_nettype wire

FILE: sv/ptt_seq.sv
// sequencer stepping the shared multiplier through one item
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ptt_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ptt_pkg::stat_t stat,
  output ptt_pkg::ctrl_t      ctrl
);
  import ptt_pkg::*;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  assign in_ready   = (state == S_IDLE);
  assign ctrl.state = state;
  assign ctrl.idx   = idx;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL0;
      S_MUL0:  state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_SUM;
      S_SUM:   state_next = S_ABS;
      S_ABS:   state_next = S_TMUL;
      S_TMUL:  state_next = S_PRED;
      S_PRED: begin
        if (stat.out_free) state_next = stat.train ? S_LRERR : S_IDLE;
      end
      S_LRERR: state_next = S_LRCAP;
      S_LRCAP: begin
        state_next = S_UMUL;
        idx_next   = '0;
      end
      S_UMUL:  state_next = S_UADD;
      S_UADD: begin
        if (idx == LAST_LANE) begin
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_UMUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  `ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == S_MUL0, "accept did not start dot product")
  `ASSERT_NEXT(a_last_lane_done, clk, rst, state == S_UADD && idx == LAST_LANE, state == S_IDLE, "update did not end after last lane")
  `ASSERT_ALWAYS(a_idx_range, clk, rst, idx <= LAST_LANE, "lane index out of range")

endmodule
`default_nettype wire

FILE: sv/perceptron_tanh_trainer_unit.sv
// top level of the perceptron trainer: datapath, weights and handshakes
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// single-layer perceptron with piecewise-linear tanh, trained by the delta rule.
// each input item carries a q1.14 sample (x_sample, y_sample), an action
// (0 classify, 1 classify then train) and a target sign. the block forms
// w0*x + w1*y + w2*1.0 with three signed q7.16 weights, takes tanh of it and
// returns one item: prediction (q1.14) and class_positive. a train item then
// moves each weight by learning_rate*(target-prediction)*input, rounded and
// saturated to 24 bits; the next item always sees the updated weights.
// all products go through one shared registered multiplier under a small
// sequencer, so in_ready is high only between items: a classify item steps
// through the dot product and tanh interpolation, a train item adds error
// scaling and three weight updates (one multiply each). the result is
// registered in the prediction step after the tanh step; if the previous result
// is still waiting, the block holds there until it is taken. learning_rate is
// written through the cfg channel (always ready, reset 655, about 0.01) and
// should only be changed while the block is idle. weights reset to zero.
module perceptron_tanh_trainer_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input item channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 action,
  input  wire logic signed [ptt_pkg::S_W-1:0]       x_sample,
  input  wire logic signed [ptt_pkg::S_W-1:0]       y_sample,
  input  wire logic                                 target_positive,
  // result item channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [ptt_pkg::S_W-1:0]            prediction,
  output logic                                      class_positive,
  // learning rate write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ptt_pkg::LR_W-1:0]             learning_rate
);
  import ptt_pkg::*;

  localparam int P_W  = MUL_A_W + MUL_B_W;
  localparam int WS_W = W_W + 2;
  localparam logic signed [P_W-1:0]   ROUND   = P_W'(1) <<< (UPD_SHIFT - 1);
  localparam logic signed [WS_W-1:0]  W_MAX   = WS_W'(8388607);
  localparam logic signed [WS_W-1:0]  W_MIN   = -WS_W'(8388608);
  localparam logic signed [ERR_W-1:0] ERR_POS = ERR_W'(ONE_Q14);
  localparam logic signed [ERR_W-1:0] ERR_NEG = -ERR_W'(ONE_Q14);

  ctrl_t ctrl;
  stat_t stat;

  // latched item
  logic signed [S_W-1:0] x_reg, y_reg;
  logic                  train_reg, tgt_reg;

  logic [LR_W-1:0]          lr_reg;
  logic signed [W_W-1:0]    w_reg [NUM_W];

  // shared multiplier
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [P_W-1:0]     p;

  // dot product and tanh
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-SUM_SHIFT-1:0] s_q;
  logic [ACC_W-SUM_SHIFT-1:0] abs_s;
  logic                      neg_reg, sat_reg;
  logic [17:0]               frac_reg;
  logic [3:0]                seg;
  logic [14:0]               knot_lo, knot_hi, knot_diff, mag;
  logic signed [S_W-1:0]     mag_s, pred_next;
  logic                      out_free;

  // update
  logic signed [ERR_W-1:0]   err;
  logic signed [MUL_A_W-1:0] lrerr;
  logic signed [S_W-1:0]     lane_x;
  logic signed [P_W-1:0]     round_p;
  logic signed [WS_W-1:0]    wsum;
  logic signed [W_W-1:0]     w_new;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign stat.train    = train_reg;
  assign stat.out_free = out_free;

  ptt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ptt_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (p)
  );

  // input of the lane being updated
  always_comb begin
    case (ctrl.idx)
      2'd0:    lane_x = x_reg;
      2'd1:    lane_x = y_reg;
      default: lane_x = ONE_Q14;
    endcase
  end

  // tanh segment lookup
  assign seg       = {1'b0, frac_reg[17:15]};
  assign knot_lo   = tanh_knot(seg);
  assign knot_hi   = tanh_knot(seg + 4'd1);
  assign knot_diff = knot_hi - knot_lo;

  // operand selection per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.state)
      S_MUL0: begin
        op_a = MUL_A_W'(w_reg[0]);
        op_b = MUL_B_W'(x_reg);
      end
      S_MUL1: begin
        op_a = MUL_A_W'(w_reg[1]);
        op_b = MUL_B_W'(y_reg);
      end
      S_MUL2: begin
        op_a = MUL_A_W'(w_reg[2]);
        op_b = MUL_B_W'(ONE_Q14);
      end
      // kept through the result wait so the interpolation product stays put
      S_TMUL, S_PRED: begin
        op_a = signed'(MUL_A_W'(knot_diff));
        op_b = signed'(MUL_B_W'(frac_reg[14:0]));
      end
      S_LRERR: begin
        op_a = signed'(MUL_A_W'(lr_reg));
        op_b = err;
      end
      S_UMUL: begin
        op_a = lrerr;
        op_b = MUL_B_W'(lane_x);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // weighted sum reduced to q.16, then magnitude for the table
  assign s_q   = acc[ACC_W-1:SUM_SHIFT];
  assign abs_s = s_q[ACC_W-SUM_SHIFT-1] ? (ACC_W-SUM_SHIFT)'(-s_q)
                                        : (ACC_W-SUM_SHIFT)'(s_q);

  // interpolated magnitude, p holds diff * fraction here
  assign mag       = sat_reg ? 15'(ONE_Q14) : knot_lo + 15'(p[27:15]);
  assign mag_s     = signed'({1'b0, mag});
  assign pred_next = neg_reg ? -mag_s : mag_s;

  // error against +-1.0
  assign err = (tgt_reg ? ERR_POS : ERR_NEG) - ERR_W'(prediction);

  // rounded step, then saturating add
  assign round_p = p + ROUND;
  assign wsum    = WS_W'(w_reg[ctrl.idx])
                 + WS_W'(signed'(round_p[P_W-1:UPD_SHIFT]));
  always_comb begin
    if (wsum > W_MAX)      w_new = W_MAX[W_W-1:0];
    else if (wsum < W_MIN) w_new = W_MIN[W_W-1:0];
    else                   w_new = wsum[W_W-1:0];
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_reg     <= x_sample;
      y_reg     <= y_sample;
      train_reg <= action;
      tgt_reg   <= target_positive;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (ctrl.state)
      S_MUL1: acc <= ACC_W'(p);
      S_MUL2: acc <= acc + ACC_W'(p);
      S_SUM:  acc <= acc + ACC_W'(p);
      S_ABS: begin
        neg_reg  <= s_q[ACC_W-SUM_SHIFT-1];
        sat_reg  <= |abs_s[ACC_W-SUM_SHIFT-1:18];
        frac_reg <= abs_s[17:0];
      end
      S_LRCAP: lrerr <= MUL_A_W'(p);
      default: ;
    endcase
  end

  // result register doubles as the prediction used for the error
  always_ff @(posedge clk) begin
    if (ctrl.state == S_PRED && out_free) begin
      prediction     <= pred_next;
      class_positive <= !neg_reg && (mag != 15'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.state == S_PRED && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // learning rate and weights
  always_ff @(posedge clk) begin
    if (rst) begin
      lr_reg <= LR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lr_reg <= learning_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_W; i++) w_reg[i] <= '0;
    end else if (ctrl.state == S_UADD) begin
      w_reg[ctrl.idx] <= w_new;
    end
  end

  `ASSERT_NEXT(a_weights_hold, clk, rst, ctrl.state != S_UADD, $stable(w_reg[0]) && $stable(w_reg[1]) && $stable(w_reg[2]), "weights changed outside update")
  `ASSERT_IMPLIES(a_result_after_pred, clk, rst, $rose(out_valid), $past(ctrl.state == S_PRED), "result raised outside prediction step")
  `ASSERT_IMPLIES(a_class_sign, clk, rst, out_valid && class_positive, !prediction[S_W-1] && prediction != '0, "class disagrees with prediction sign")

endmodule
`default_nettype wire
